// File: rtl/snc_pkg.sv
// ----------------------------------------------------------------------------
// snc_pkg: shared types and constants of the script number codec
// Holds the function codes, status codes, byte masks and the queue item
// passed from the classifying front end to the byte emitting back end.
// ----------------------------------------------------------------------------
package snc_pkg;

    // Longest byte form accepted on decode
    localparam logic [3:0] MAX_BYTES = 4'd4;

    // Function codes
    localparam logic FUNC_DECODE = 1'b0;
    localparam logic FUNC_ENCODE = 1'b1;

    // Byte masks of the sign-magnitude form
    localparam logic [7:0] SIGN_MASK = 8'h80;
    localparam logic [7:0] MAG_MASK  = 8'h7f;
    localparam logic [7:0] BYTE_MASK = 8'hff;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_LONG    = 2'd1,
        ST_NOT_MIN = 2'd2
    } t_status;

    // One classified item: decoded value, or encode magnitude and byte count
    typedef struct packed {
        logic        is_enc;
        logic        empty;
        t_status     status;
        logic [63:0] value;
        logic [3:0]  nbytes;
        logic        extra;
        logic        neg;
    } t_item;

endpackage

// File: rtl/script_number_codec.sv
// ----------------------------------------------------------------------------
// script_number_codec: script number encoder and decoder
// Converts between signed 64-bit values and the little-endian
// sign-magnitude byte form of script numbers.
// ----------------------------------------------------------------------------
// A decode item gives one result; an encode item gives one result per output
// byte (one to nine, or a single empty result for zero). The back end emits
// one result per cycle from the output register while the output side is
// ready; the front end classifies in the accept cycle and a two-entry queue
// lets new items enter while earlier ones still emit bytes. A result passes
// from its queue entry into the output register before it is presented.
module script_number_codec (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_func,
    input  logic [63:0]        i_packed_bytes,
    input  logic [3:0]         i_byte_count,
    input  logic               i_require_minimal,
    input  logic signed [63:0] i_number_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [63:0] o_number_out,
    output logic [1:0]         o_status,
    output logic [7:0]         o_byte_out,
    output logic               o_empty_run,
    output logic               o_last
);

    snc_pkg::t_item item;
    snc_pkg::t_item head;
    logic           full;
    logic           nonempty;
    logic           pop;
    logic           push;
    logic [63:0]    number_out;

    assign o_in_ready = !full;
    assign push       = i_in_valid && !full;

    // Classify the incoming item
    snc_front u_front (
        .i_func            (i_func),
        .i_packed_bytes    (i_packed_bytes),
        .i_byte_count      (i_byte_count),
        .i_require_minimal (i_require_minimal),
        .i_number_in       (i_number_in),
        .o_item            (item)
    );

    // Buffer classified items
    snc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (item),
        .o_full     (full),
        .i_pop      (pop),
        .o_nonempty (nonempty),
        .o_head     (head)
    );

    // Emit results
    snc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_nonempty   (nonempty),
        .i_head       (head),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_number_out (number_out),
        .o_status     (o_status),
        .o_byte_out   (o_byte_out),
        .o_empty_run  (o_empty_run),
        .o_last       (o_last)
    );

    assign o_number_out = $signed(number_out);

endmodule

// File: rtl/snc_front.sv
// ----------------------------------------------------------------------------
// snc_front: item classifier
// Decodes a byte form into its value and status, or reduces a number to
// magnitude, sign and result byte count for the back end.
// ----------------------------------------------------------------------------
module snc_front (
    input  logic                i_func,
    input  logic [63:0]         i_packed_bytes,
    input  logic [3:0]          i_byte_count,
    input  logic                i_require_minimal,
    input  logic signed [63:0]  i_number_in,
    output snc_pkg::t_item      o_item
);

    logic [2:0]  top_idx;
    logic [2:0]  below_idx;
    logic [7:0]  top_b;
    logic [7:0]  below_b;
    logic [63:0] dmask;
    logic [63:0] dval;
    logic        not_min;
    logic [63:0] emag;
    logic [3:0]  nm;
    logic [2:0]  etop_idx;
    logic [7:0]  etop_b;

    // Decode: pick top bytes, mask to length, strip sign and negate when negative
    always_comb begin
        top_idx   = 3'(i_byte_count - 4'd1);
        below_idx = top_idx - 3'd1;
        top_b     = 8'(i_packed_bytes >> {top_idx, 3'b000});
        below_b   = 8'(i_packed_bytes >> {below_idx, 3'b000});
        for (int i = 0; i < 8; i++) begin
            dmask[8*i +: 8] = (4'(i) < i_byte_count) ? snc_pkg::BYTE_MASK : 8'h00;
        end
        dmask[{top_idx, 3'b111}] = 1'b0;
        dval = i_packed_bytes & dmask;
        if (top_b[7]) begin
            dval = 64'd0 - dval;
        end
        not_min = i_require_minimal && ((top_b & snc_pkg::MAG_MASK) == 8'h00) &&
                  ((i_byte_count < 4'd2) || ((below_b & snc_pkg::SIGN_MASK) == 8'h00));
    end

    // Encode: magnitude, significant bytes, and whether a sign byte is added
    always_comb begin
        emag = i_number_in[63] ? (64'd0 - 64'(i_number_in)) : 64'(i_number_in);
        nm   = 4'd0;
        for (int i = 0; i < 8; i++) begin
            if (emag[8*i +: 8] != 8'h00) begin
                nm = 4'(i + 1);
            end
        end
        etop_idx = 3'(nm - 4'd1);
        etop_b   = 8'(emag >> {etop_idx, 3'b000});
    end

    // Build the queue item
    always_comb begin
        o_item        = '0;
        o_item.status = snc_pkg::ST_OK;
        o_item.nbytes = 4'd1;
        if (i_func == snc_pkg::FUNC_ENCODE) begin
            o_item.is_enc = 1'b1;
            o_item.neg    = i_number_in[63];
            o_item.value  = emag;
            if (nm == 4'd0) begin
                o_item.empty = 1'b1;
            end else begin
                o_item.extra  = etop_b[7];
                o_item.nbytes = nm + {3'd0, etop_b[7]};
            end
        end else if (i_byte_count == 4'd0) begin
            o_item.value = 64'd0;
        end else if (i_byte_count > snc_pkg::MAX_BYTES) begin
            o_item.status = snc_pkg::ST_LONG;
        end else if (not_min) begin
            o_item.status = snc_pkg::ST_NOT_MIN;
        end else begin
            o_item.value = dval;
        end
    end

endmodule

// File: rtl/snc_queue.sv
// ----------------------------------------------------------------------------
// snc_queue: two-entry item queue
// Decouples the front end from the back end so each side stalls on its own.
// ----------------------------------------------------------------------------
module snc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  snc_pkg::t_item  i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_nonempty,
    output snc_pkg::t_item  o_head
);

    snc_pkg::t_item r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;
    logic           n_wr_ptr;
    logic           n_rd_ptr;
    logic [1:0]     n_count;

    assign o_full     = (r_count == 2'd2);
    assign o_nonempty = (r_count != 2'd0);
    assign o_head     = r_mem[r_rd_ptr];

    // Advance pointers and count
    always_comb begin
        n_wr_ptr = i_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed item
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// File: rtl/snc_back.sv
// ----------------------------------------------------------------------------
// snc_back: result emitter
// Walks the head item one result per cycle, while the output is free or
// accepted, into the output register and pops the item on its final result.
// ----------------------------------------------------------------------------
module snc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_nonempty,
    input  snc_pkg::t_item  i_head,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [63:0]     o_number_out,
    output logic [1:0]      o_status,
    output logic [7:0]      o_byte_out,
    output logic            o_empty_run,
    output logic            o_last
);

    logic [3:0]  r_idx;
    logic        r_out_valid;
    logic [63:0] r_number;
    logic [1:0]  r_status;
    logic [7:0]  r_byte;
    logic        r_empty;
    logic        r_last;

    logic        load;
    logic        is_last;
    logic [7:0]  sel_byte;
    logic [63:0] n_number;
    logic [1:0]  n_status;
    logic [7:0]  n_byte;
    logic        n_empty;

    assign load    = i_nonempty && (!r_out_valid || i_out_ready);
    assign is_last = !i_head.is_enc || i_head.empty || (r_idx == i_head.nbytes - 4'd1);
    assign o_pop   = load && is_last;

    // Form the result for the current byte index
    always_comb begin
        sel_byte = 8'(i_head.value >> {r_idx[2:0], 3'b000});
        n_number = 64'd0;
        n_status = 2'(snc_pkg::ST_OK);
        n_byte   = 8'h00;
        n_empty  = 1'b0;
        if (!i_head.is_enc) begin
            n_number = i_head.value;
            n_status = 2'(i_head.status);
        end else if (i_head.empty) begin
            n_empty = 1'b1;
        end else if (is_last && i_head.extra) begin
            n_byte = i_head.neg ? snc_pkg::SIGN_MASK : 8'h00;
        end else if (is_last && i_head.neg) begin
            n_byte = sel_byte | snc_pkg::SIGN_MASK;
        end else begin
            n_byte = sel_byte;
        end
    end

    // Hold the byte index and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx       <= is_last ? 4'd0 : r_idx + 4'd1;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Load the output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_number <= n_number;
            r_status <= n_status;
            r_byte   <= n_byte;
            r_empty  <= n_empty;
            r_last   <= is_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_number_out = r_number;
    assign o_status     = r_status;
    assign o_byte_out   = r_byte;
    assign o_empty_run  = r_empty;
    assign o_last       = r_last;

endmodule
